[sv/ptw_pkg.sv]
// Package for the four-level page table walker: word types, status,
// command and register index codes. No dependencies.
package ptw_pkg;

   localparam int unsigned ADDR_W   = 48;
   localparam int unsigned BYTES_W  = 32;
   localparam int unsigned ATTR_W   = 12;
   localparam int unsigned PFN_W    = ADDR_W - 12;
   localparam int unsigned IDX_W    = 9;
   localparam int unsigned COUNT_W  = BYTES_W - 11;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic CMD_MAP    = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_ZERO_LEN   = 2'd1;
   localparam logic [1:0] STATUS_EXHAUSTED  = 2'd2;
   localparam logic [1:0] STATUS_NOT_MAPPED = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BASE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_ATTR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_ATTR  = 2'd2;

   localparam logic [ATTR_W-1:0] TABLE_ATTR_RESET = 12'h407;
   localparam logic [ATTR_W-1:0] PAGE_ATTR_RESET  = 12'h447;

   typedef struct packed {
      logic               command;
      logic [ADDR_W-1:0]  virt_addr;
      logic [ADDR_W-1:0]  phys_addr;
      logic [BYTES_W-1:0] map_bytes;
   } ptw_req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [ADDR_W-1:0] leaf_entry;
   } ptw_rsp_type;

endpackage

[sv/ptw_ram.sv]
// Generic simple dual-port RAM: one write and one registered read per cycle.
// No dependencies.
module ptw_ram #(
   parameter int unsigned WIDTH = 48,
   parameter int unsigned DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[sv/four_level_page_table_walker_core.sv]
// Lookup: S_RD and S_CHK for each of four levels, then S_DONE fills the response
// register; map: three levels and an S_LEAF write per page; zero-length map: S_DONE
// at once. The next word is taken in S_IDLE. Each level costs a registered table
// memory read plus a check state, so one word is in flight at a time; a response may
// wait while the next word enters. Active-high synchronous reset; a clearing pass
// then zeroes POOL_PAGES*512 entries, req_ready low. Depends on ptw_pkg and ptw_ram.
module four_level_page_table_walker_core
   import ptw_pkg::*;
#(
   parameter int unsigned POOL_PAGES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ptw_req_type          req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ptw_rsp_type          rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_data
);

   // pool geometry
   localparam int unsigned PW        = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
   localparam int unsigned NFW       = $clog2(POOL_PAGES + 1);
   localparam int unsigned DEPTH     = POOL_PAGES * 512;
   localparam int unsigned AW        = PW + IDX_W;
   localparam int unsigned LAST_ADDR = DEPTH - 1;

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_RD    = 6'b000100,
      S_CHK   = 6'b001000,
      S_LEAF  = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   // table index for a level; level 0 is the leaf table
   function automatic logic [IDX_W-1:0] lvl_index(input logic [PFN_W-1:0] vpn,
                                                  input logic [1:0] lvl);
      logic [IDX_W-1:0] idx;
      unique case (lvl)
         2'd3:    idx = vpn[35:27];
         2'd2:    idx = vpn[26:18];
         2'd1:    idx = vpn[17:9];
         default: idx = vpn[8:0];
      endcase
      return idx;
   endfunction

   state_type            state_ff, state_in;
   logic [AW-1:0]        clr_ff, clr_in;
   logic [NFW-1:0]       nf_ff, nf_in;          // next free pool page
   logic [PFN_W-1:0]     base_ff, base_in;      // pool base, page number only
   logic [ATTR_W-1:0]    tattr_ff, tattr_in;
   logic [ATTR_W-1:0]    pattr_ff, pattr_in;
   logic                 cmd_ff, cmd_in;
   logic [PFN_W-1:0]     vp_ff, vp_in;          // current virtual page
   logic [PFN_W-1:0]     pp_ff, pp_in;          // current physical page
   logic [COUNT_W-1:0]   rem_ff, rem_in;        // pages still to map
   logic [1:0]           lvl_ff, lvl_in;
   logic [PW-1:0]        page_ff, page_in;      // pool page of the table being walked
   logic [AW-1:0]        addr_ff, addr_in;      // entry last read
   logic [ADDR_W-1:0]    last_ff, last_in;      // last leaf written
   logic [1:0]           res_st_ff, res_st_in;
   logic [ADDR_W-1:0]    res_leaf_ff, res_leaf_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   ptw_rsp_type          rsp_ff, rsp_in;

   // table memory ports
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [ADDR_W-1:0]    wr_data;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic [ADDR_W-1:0]    rd_data;

   // descriptor decode
   logic [PFN_W-1:0]     desc_off;
   logic                 desc_in_pool;
   logic [ADDR_W-1:0]    leaf_word;
   logic [COUNT_W-1:0]   page_count;

   ptw_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // offset of the descriptor's table from the pool base, in pages (mod 2^36)
   assign desc_off     = rd_data[ADDR_W-1:12] - base_ff;
   assign desc_in_pool = desc_off < PFN_W'(POOL_PAGES);
   assign leaf_word    = {pp_ff, pattr_ff};
   // pages started: ceil(bytes / 4096), at most 2^20
   assign page_count   = COUNT_W'(({1'b0, req_data.map_bytes} + 33'd4095) >> 12);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      nf_in        = nf_ff;
      base_in      = base_ff;
      tattr_in     = tattr_ff;
      pattr_in     = pattr_ff;
      cmd_in       = cmd_ff;
      vp_in        = vp_ff;
      pp_in        = pp_ff;
      rem_in       = rem_ff;
      lvl_in       = lvl_ff;
      page_in      = page_ff;
      addr_in      = addr_ff;
      last_in      = last_ff;
      res_st_in    = res_st_ff;
      res_leaf_in  = res_leaf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = addr_ff;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = {page_ff, lvl_index(vp_ff, lvl_ff)};

      // register writes; the user must issue them only while idle, the block does not enforce it
      if (csr_valid) begin
         unique case (csr_index)
            CSR_POOL_BASE:  base_in  = csr_data[ADDR_W-1:12];
            CSR_TABLE_ATTR: tattr_in = csr_data[ATTR_W-1:0];
            CSR_PAGE_ATTR:  pattr_in = csr_data[ATTR_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            if (clr_ff == AW'(LAST_ADDR)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               cmd_in  = req_data.command;
               vp_in   = req_data.virt_addr[ADDR_W-1:12];
               pp_in   = req_data.phys_addr[ADDR_W-1:12];
               rem_in  = page_count;
               lvl_in  = 2'd3;
               page_in = '0;
               last_in = '0;
               if (req_data.command == CMD_MAP && req_data.map_bytes == '0) begin
                  res_st_in   = STATUS_ZERO_LEN;
                  res_leaf_in = '0;
                  state_in    = S_DONE;
               end else begin
                  state_in = S_RD;
               end
            end
         end

         S_RD: begin
            rd_en    = 1'b1;
            addr_in  = rd_addr;
            state_in = S_CHK;
         end

         S_CHK: begin
            if (lvl_ff == 2'd0) begin
               // leaf read of a lookup: returned whether valid or not
               res_st_in   = STATUS_OK;
               res_leaf_in = rd_data;
               state_in    = S_DONE;
            end else if (!rd_data[0] && cmd_ff == CMD_LOOKUP) begin
               res_st_in   = STATUS_NOT_MAPPED;
               res_leaf_in = '0;
               state_in    = S_DONE;
            end else if (!rd_data[0] && nf_ff >= NFW'(POOL_PAGES)) begin
               res_st_in   = STATUS_EXHAUSTED;
               res_leaf_in = last_ff;
               state_in    = S_DONE;
            end else if (rd_data[0] && !desc_in_pool) begin
               // descriptor points outside the pool (last_ff is zero for lookups)
               res_st_in   = STATUS_NOT_MAPPED;
               res_leaf_in = last_ff;
               state_in    = S_DONE;
            end else begin
               if (!rd_data[0]) begin
                  // allocate: new descriptor written back, followed straight away
                  wr_en   = 1'b1;
                  wr_data = {base_ff + PFN_W'(nf_ff), tattr_ff};
                  nf_in   = nf_ff + 1'b1;
                  page_in = nf_ff[PW-1:0];
               end else begin
                  page_in = desc_off[PW-1:0];
               end
               if (lvl_ff == 2'd1 && cmd_ff == CMD_MAP) begin
                  state_in = S_LEAF;
               end else begin
                  lvl_in   = lvl_ff - 1'b1;
                  state_in = S_RD;
               end
            end
         end

         S_LEAF: begin
            wr_en   = 1'b1;
            wr_addr = {page_ff, vp_ff[IDX_W-1:0]};
            wr_data = leaf_word;
            last_in = leaf_word;
            if (rem_ff == COUNT_W'(1)) begin
               res_st_in   = STATUS_OK;
               res_leaf_in = leaf_word;
               state_in    = S_DONE;
            end else begin
               rem_in   = rem_ff - 1'b1;
               vp_in    = vp_ff + 1'b1;
               pp_in    = pp_ff + 1'b1;
               lvl_in   = 2'd3;
               page_in  = '0;
               state_in = S_RD;
            end
         end

         S_DONE: begin
            // wait for the response register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = res_st_ff;
               rsp_in.leaf_entry  = res_leaf_ff;
               state_in           = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         nf_ff        <= NFW'(1);
         base_ff      <= '0;
         tattr_ff     <= TABLE_ATTR_RESET;
         pattr_ff     <= PAGE_ATTR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         nf_ff        <= nf_in;
         base_ff      <= base_in;
         tattr_ff     <= tattr_in;
         pattr_ff     <= pattr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      vp_ff       <= vp_in;
      pp_ff       <= pp_in;
      rem_ff      <= rem_in;
      lvl_ff      <= lvl_in;
      page_ff     <= page_in;
      addr_ff     <= addr_in;
      last_ff     <= last_in;
      res_st_ff   <= res_st_in;
      res_leaf_ff <= res_leaf_in;
      rsp_ff      <= rsp_in;
   end

endmodule

[sv/ptw_checker.sv]
// Port-level checks for the page table walker, bound to the top level.
// Depends on ptw_pkg.
module ptw_checker
   import ptw_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input ptw_req_type          req_data,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input ptw_rsp_type          rsp_data,
   input logic                 csr_valid,
   input logic                 csr_ready,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [ADDR_W-1:0]    csr_data
);

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed while stalled");

   // a new response only appears while the request side is closed
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response raised while walker idle");

   // zero-length map with an empty output is answered through S_DONE and the response register
   a_zero_len: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.command == CMD_MAP &&
      req_data.map_bytes == '0 && !rsp_valid
      |-> ##2 (rsp_valid && rsp_data.status == STATUS_ZERO_LEN))
      else $error("zero-length map not answered");

   // zero-length status carries no leaf
   a_zero_leaf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_ZERO_LEN |-> rsp_data.leaf_entry == '0)
      else $error("zero-length response with a leaf");

endmodule

bind four_level_page_table_walker_core ptw_checker u_ptw_checker (.*);

[sim/tb_top.sv]
// Self-checking bench for four_level_page_table_walker_core: a scoreboard class
// keeps its own table pool and bump counter. Depends on ptw_pkg and the core.
module tb_top;
   import ptw_pkg::*;

   localparam int unsigned TB_POOL_PAGES    = 16;
   localparam int unsigned ENTRIES          = 512;
   // Tail long enough to cover one lookup plus the response register.
   localparam int unsigned SETTLE_CYCLES    = 16;
   // Cycles with no word moving on any channel. The longest quiet stretch is
   // the clearing pass or one long map, well under this.
   localparam int unsigned WATCHDOG_LIMIT   = 300000;
   localparam int unsigned PHASES           = 8;
   localparam int unsigned ITEMS_PER_PHASE  = 225;
   localparam int unsigned HOT_DEPTH        = 128;
   // Index 3 decodes to nothing; writing it must not disturb the others.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   // ------------------------------------------------------------------------
   // Scoreboard: mirrors the table pool, predicts one response per request
   // word and checks responses in order.
   // ------------------------------------------------------------------------
   class ptw_scoreboard;
      logic [ADDR_W-1:0] tables [TB_POOL_PAGES*ENTRIES];
      int unsigned       next_free;
      logic [ADDR_W-1:0] pool_base;
      logic [ATTR_W-1:0] table_attr;
      logic [ATTR_W-1:0] page_attr;
      ptw_rsp_type       pending_q [$];
      logic [ADDR_W-1:0] mapped_va [$];   // first page of each good map
      int unsigned       errors;

      function new();
         foreach (tables[i]) tables[i] = '0;
         next_free  = 1;
         pool_base  = '0;
         table_attr = TABLE_ATTR_RESET;
         page_attr  = PAGE_ATTR_RESET;
         errors     = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
         case (idx)
            CSR_POOL_BASE:  pool_base  = value;
            CSR_TABLE_ATTR: table_attr = value[ATTR_W-1:0];
            CSR_PAGE_ATTR:  page_attr  = value[ATTR_W-1:0];
            default: ;
         endcase
      endfunction

      // Three-level descent to the leaf slot; allocates missing tables on maps.
      function automatic logic [1:0] walk(input logic [ADDR_W-1:0] va, input bit alloc,
                                          output int unsigned slot);
         int unsigned       page;
         int unsigned       ent;
         int                lvl;
         logic [ADDR_W-1:0] off;
         logic [ADDR_W-1:0] fresh;
         page = 0;
         slot = 0;
         for (lvl = 3; lvl > 0; lvl--) begin
            ent = page * ENTRIES + int'(va[12 + 9*lvl +: IDX_W]);
            if (!tables[ent][0]) begin
               if (!alloc) return STATUS_NOT_MAPPED;
               if (next_free >= TB_POOL_PAGES) return STATUS_EXHAUSTED;
               fresh = {pool_base[ADDR_W-1:12], 12'h000} + (ADDR_W'(next_free) << 12);
               // followed even when the attribute bits leave it invalid
               tables[ent] = fresh | ADDR_W'(table_attr);
               next_free++;
            end
            off = {tables[ent][ADDR_W-1:12], 12'h000} - {pool_base[ADDR_W-1:12], 12'h000};
            if (off >= (ADDR_W'(TB_POOL_PAGES) << 12)) return STATUS_NOT_MAPPED;
            page = int'(off >> 12);
         end
         slot = page * ENTRIES + int'(va[20:12]);
         return STATUS_OK;
      endfunction

      function void note_word(ptw_req_type w);
         ptw_rsp_type       r;
         logic [32:0]       pages;
         logic [32:0]       n;
         logic [ADDR_W-1:0] va;
         logic [ADDR_W-1:0] pa;
         logic [ADDR_W-1:0] step;
         int unsigned       slot;
         r.status     = STATUS_OK;
         r.leaf_entry = '0;
         if (w.command == CMD_LOOKUP) begin
            r.status = walk(w.virt_addr, 1'b0, slot);
            if (r.status == STATUS_OK) r.leaf_entry = tables[slot];
         end else if (w.map_bytes == '0) begin
            r.status = STATUS_ZERO_LEN;
         end else begin
            pages = ({1'b0, w.map_bytes} + 33'd4095) >> 12;
            va    = {w.virt_addr[ADDR_W-1:12], 12'h000};
            pa    = {w.phys_addr[ADDR_W-1:12], 12'h000};
            for (n = 0; n < pages; n++) begin
               step     = ADDR_W'(n) << 12;
               r.status = walk(va + step, 1'b1, slot);
               if (r.status != STATUS_OK) break;
               r.leaf_entry = (pa + step) | ADDR_W'(page_attr);
               tables[slot] = r.leaf_entry;
               if (n == 0) begin
                  mapped_va.push_back(va);
                  if (mapped_va.size() > HOT_DEPTH) void'(mapped_va.pop_front());
               end
            end
         end
         pending_q.push_back(r);
      endfunction

      task report_mismatch(string what, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
         errors++;
         $display("MISMATCH %s: got %h want %h", what, got, want);
      endtask

      task check_word(ptw_rsp_type got);
         ptw_rsp_type want;
         if (pending_q.size() == 0) begin
            report_mismatch("response with none outstanding", got.leaf_entry, '0);
            return;
         end
         want = pending_q.pop_front();
         if (got.status !== want.status)
            report_mismatch("status", ADDR_W'(got.status), ADDR_W'(want.status));
         if (got.leaf_entry !== want.leaf_entry)
            report_mismatch("leaf_entry", got.leaf_entry, want.leaf_entry);
      endtask
   endclass

   // ------------------------------------------------------------------------
   // Block hookup
   // ------------------------------------------------------------------------
   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   ptw_req_type          req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   ptw_rsp_type          rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [ADDR_W-1:0]    csr_data;

   four_level_page_table_walker_core #(.POOL_PAGES(TB_POOL_PAGES)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   ptw_scoreboard sb;
   int unsigned   send_idle_pct;    // chance the sender holds off a cycle
   int unsigned   recv_stall_pct;   // chance the receiver drops ready
   int unsigned   quiet_cycles;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Receiver: ready redrawn every cycle; free to toggle under the handshake.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Monitor: every word that moves goes to the scoreboard. Responses are
   // checked before a same-edge request is noted, so ordering stays correct.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
         if (rsp_valid && rsp_ready) sb.check_word(rsp_data);
         if (req_valid && req_ready) sb.note_word(req_data);
      end
   end

   // Watchdog: any word on any channel counts as progress.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------
   function automatic logic [ADDR_W-1:0] rand48();
      return ADDR_W'({$urandom, $urandom});
   endfunction

   function automatic ptw_req_type make_word(logic cmd, logic [ADDR_W-1:0] va,
                                             logic [ADDR_W-1:0] pa, logic [BYTES_W-1:0] len);
      ptw_req_type w;
      w.command   = cmd;
      w.virt_addr = va;
      w.phys_addr = pa;
      w.map_bytes = len;
      return w;
   endfunction

   // Called at an edge; returns at the edge the word is taken, valid left high
   // so a following word can go out back to back.
   task automatic send_word(input ptw_req_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
   endtask

   // One register write; valid stays high for a following write.
   task automatic csr_put(input logic [CSR_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic write_config(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] tattr,
                               input logic [ADDR_W-1:0] pattr);
      csr_put(CSR_POOL_BASE, base);
      csr_put(CSR_TABLE_ATTR, tattr);
      csr_put(CSR_PAGE_ATTR, pattr);
      csr_valid <= 1'b0;
   endtask

   // Sender holds off until every response is back, then a short tail. It waits for an
   // edge first, so a word taken at the calling edge is already noted.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly addresses near earlier maps so walks get past the root; the rest
   // anywhere in the 48-bit space.
   function automatic ptw_req_type random_word();
      ptw_req_type       w;
      int unsigned       pick;
      int unsigned       lenpick;
      logic [ADDR_W-1:0] hot;
      w.command   = ($urandom_range(99) < 45) ? CMD_LOOKUP : CMD_MAP;
      w.phys_addr = rand48();
      pick        = $urandom_range(99);
      if (sb.mapped_va.size() != 0 && pick < 75) begin
         hot = sb.mapped_va[$urandom_range(sb.mapped_va.size() - 1)];
         if (pick < 55)
            w.virt_addr = hot + (ADDR_W'($urandom_range(15)) << 12)
                              + ADDR_W'($urandom_range(4095));
         else
            w.virt_addr = {hot[ADDR_W-1:21], 21'($urandom)};
      end else begin
         w.virt_addr = rand48();
      end
      lenpick = $urandom_range(99);
      if (w.command == CMD_LOOKUP)
         w.map_bytes = $urandom;
      else if (lenpick < 3)
         w.map_bytes = '0;
      else if (lenpick < 88)
         w.map_bytes = $urandom_range(32'h4000, 1);
      else
         w.map_bytes = $urandom_range(32'h40000, 1);
      return w;
   endfunction

   task automatic phase_config(input int unsigned p);
      case (p)
         0: write_config('0, ADDR_W'(TABLE_ATTR_RESET), ADDR_W'(PAGE_ATTR_RESET));
         1: write_config('0, ADDR_W'(12'hfff), '0);
         3: write_config(48'hffff_ffff_f000, ADDR_W'(12'h001), ADDR_W'(12'hfff));
         5: write_config(rand48(), rand48(), rand48());
         6: write_config('0, ADDR_W'(TABLE_ATTR_RESET), rand48());
         7: write_config(48'h0000_0000_1000, rand48(), rand48());
         default: write_config('0, rand48(), rand48());
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      sb             = new();
      send_idle_pct  = 0;
      recv_stall_pct <= 0;
      quiet_cycles   <= 0;
      rsp_ready      <= 1'b0;
      req_valid      <= 1'b0;
      req_data       <= '0;
      csr_valid      <= 1'b0;
      csr_index      <= '0;
      csr_data       <= '0;
      reset          <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Registers are taken during the clearing pass; requests wait for it.
      csr_put(CSR_SPARE, '1);
      write_config('0, ADDR_W'(TABLE_ATTR_RESET), ADDR_W'(PAGE_ATTR_RESET));

      // Empty pool: miss at the root, then zero length.
      send_word(make_word(CMD_LOOKUP, '0, '1, '1));
      send_word(make_word(CMD_MAP, 48'h0000_1234_5678, 48'h0000_8765_4321, '0));
      // First map builds three tables; an unwritten leaf in a live table reads 0.
      send_word(make_word(CMD_MAP, '0, '0, 32'd1));
      send_word(make_word(CMD_LOOKUP, '0, '0, '0));
      send_word(make_word(CMD_LOOKUP, 48'h0000_0000_1000, '0, '0));
      // Top of the space: VA and PA both wrap back through zero.
      send_word(make_word(CMD_MAP, '1, '1, 32'h2001));
      send_word(make_word(CMD_LOOKUP, '1, '0, '0));
      send_word(make_word(CMD_LOOKUP, 48'h0000_0000_1fff, '0, '0));
      // Miss one level down.
      send_word(make_word(CMD_LOOKUP, 48'h0000_0020_0000, '0, '0));
      // Page-length edges: exactly one page, one byte over.
      send_word(make_word(CMD_MAP, 48'h0000_0000_5000, 48'h8000_0000_0123, 32'd4096));
      send_word(make_word(CMD_MAP, 48'h0000_0000_7abc, 48'h0000_0000_5000, 32'd4097));

      // Table attributes with the valid bit clear: followed now, stale later.
      settle();
      write_config('0, '0, ADDR_W'(12'hfff));
      send_word(make_word(CMD_MAP, 48'h0000_0040_0000, 48'h0000_0000_9000, 32'd1));
      send_word(make_word(CMD_LOOKUP, 48'h0000_0040_0000, '0, '0));
      send_word(make_word(CMD_MAP, 48'h0000_0040_0000, 48'h0000_0000_a000, 32'd1));

      // Pool moved to the top page: old descriptors land on other pool pages.
      settle();
      write_config(48'hffff_ffff_f000, ADDR_W'(12'hfff), '0);
      send_word(make_word(CMD_LOOKUP, '0, '0, '0));
      send_word(make_word(CMD_LOOKUP, 48'hffff_ffff_f000, '0, '0));

      // Pool far away: every descriptor points outside it. Longest length too.
      settle();
      write_config(48'h1234_5678_9abc, ADDR_W'(TABLE_ATTR_RESET), ADDR_W'(PAGE_ATTR_RESET));
      send_word(make_word(CMD_LOOKUP, '0, '0, '0));
      send_word(make_word(CMD_MAP, '0, '1, '1));

      // Back home: run the pool dry, once part way through a map, once at once.
      settle();
      write_config('0, ADDR_W'(TABLE_ATTR_RESET), ADDR_W'(PAGE_ATTR_RESET));
      send_word(make_word(CMD_MAP, 48'h1000_3fff_f000, 48'h4000_0000_0000, 32'h2000));
      send_word(make_word(CMD_MAP, 48'h1000_7fff_f000, 48'h4000_0001_0000, 32'h2000));
      send_word(make_word(CMD_LOOKUP, 48'h1000_8000_0000, '0, '0));
      send_word(make_word(CMD_MAP, 48'h2000_0000_0000, 48'h0000_0000_1000, 32'd1));
      send_word(make_word(CMD_LOOKUP, 48'h1000_7fff_fabc, '0, '0));

      // Random phases: idle pattern cycles none / sender / receiver / both.
      for (int unsigned p = 0; p < PHASES; p++) begin
         settle();
         phase_config(p);
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
            1: begin send_idle_pct = 53; recv_stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct <= 53; end
            default: begin send_idle_pct = 14; recv_stall_pct <= 14; end
         endcase
         repeat (ITEMS_PER_PHASE) begin
            if ($urandom_range(99) == 0) settle();
            send_word(random_word());
         end
      end

      settle();
      if (sb.errors == 0 && sb.pending_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
